>>> rtl/core/sm3_pkg.sv
// SM3 hash engine: shared types, constants and helper functions.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sm3_pkg;

	// Round constants and the padding marker.
	localparam logic [31:0] T_LOW    = 32'h79CC4519;
	localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
	localparam logic [7:0]  PAD_MARK = 8'h80;

	// Fill level at which the 64-bit length field starts.
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'd63;

	// Initial chaining value, listed word 7 first (word 0 last).
	localparam logic [7:0][31:0] IV = {
		32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
		32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
	};

	// Source of the byte pushed into the block.
	localparam logic [1:0] BSEL_IN   = 2'd0;
	localparam logic [1:0] BSEL_MARK = 2'd1;
	localparam logic [1:0] BSEL_ZERO = 2'd2;
	localparam logic [1:0] BSEL_LEN  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       push;       // append one byte to the block
		logic [1:0] byte_sel;   // where that byte comes from
		logic       msg_byte;   // the byte is message data: count its bits
		logic [2:0] len_idx;    // length byte, 0 is most significant
		logic       round;      // run one compression round
		logic [5:0] round_idx;  // round number
		logic       last_round; // fold the working state into the chain
		logic [2:0] out_idx;    // digest word on the output
		logic       restart;    // return chain and length to reset values
	} sm3_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [5:0] fill;       // bytes held in the current block
	} sm3_sts_t;

	// Rotate left by a 5-bit amount.
	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

	// Rotated round constant for round j.
	function automatic logic [31:0] t_rot(input logic [5:0] j);
		return rotl((j < 6'd16) ? T_LOW : T_HIGH, j[4:0]);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/sm3_dpath.sv
// SM3 hash engine datapath: byte packing, message window, round logic,
// chaining value and bit length. Depends on sm3_pkg.
`default_nettype none

module sm3_dpath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire sm3_pkg::sm3_cmd_t cmd,
	input  wire  [7:0]           in_byte,
	output sm3_pkg::sm3_sts_t    sts,
	output logic [31:0]          digest_word
);

	logic [5:0]        fill_q;
	logic [63:0]       blen_q;
	logic [7:0][31:0]  chain_q;
	logic [23:0]       acc_q;
	logic [15:0][31:0] win_q;
	logic [31:0]       a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

	logic [7:0]  push_byte;
	logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
	logic [31:0] a_n, b_n, c_n, d_n, e_n, f_n, g_n, h_n;
	logic        block_done;

	assign sts.fill    = fill_q;
	assign digest_word = chain_q[cmd.out_idx];
	assign block_done  = cmd.push && (fill_q == sm3_pkg::FILL_LAST);

	// Byte chosen for this push.
	always_comb begin
		case (cmd.byte_sel)
			sm3_pkg::BSEL_IN:   push_byte = in_byte;
			sm3_pkg::BSEL_MARK: push_byte = sm3_pkg::PAD_MARK;
			sm3_pkg::BSEL_ZERO: push_byte = 8'h00;
			sm3_pkg::BSEL_LEN:  push_byte = blen_q[(6'd63 - {cmd.len_idx, 3'd0}) -: 8];
			default:            push_byte = 8'h00;
		endcase
	end

	// One compression round and the next expanded message word.
	always_comb begin
		a12 = sm3_pkg::rotl(a_q, 5'd12);
		ss1 = sm3_pkg::rotl(a12 + e_q + sm3_pkg::t_rot(cmd.round_idx), 5'd7);
		ss2 = ss1 ^ a12;
		if (cmd.round_idx < 6'd16) begin
			ff = a_q ^ b_q ^ c_q;
			gg = e_q ^ f_q ^ g_q;
		end else begin
			ff = (a_q & b_q) | (a_q & c_q) | (b_q & c_q);
			gg = (e_q & f_q) | (~e_q & g_q);
		end
		tt1 = ff + d_q + ss2 + (win_q[0] ^ win_q[4]);
		tt2 = gg + h_q + ss1 + win_q[0];
		a_n = tt1;
		b_n = a_q;
		c_n = sm3_pkg::rotl(b_q, 5'd9);
		d_n = c_q;
		e_n = sm3_pkg::perm0(tt2);
		f_n = e_q;
		g_n = sm3_pkg::rotl(f_q, 5'd19);
		h_n = g_q;
		w_new = sm3_pkg::perm1(win_q[0] ^ win_q[7] ^ sm3_pkg::rotl(win_q[13], 5'd15))
			^ sm3_pkg::rotl(win_q[3], 5'd7) ^ win_q[10];
	end

	// Fill count, bit length and chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			blen_q  <= '0;
			chain_q <= sm3_pkg::IV;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.push && cmd.msg_byte) begin
				blen_q <= blen_q + 64'd8;
			end
			if (cmd.round && cmd.last_round) begin
				chain_q <= {chain_q[7] ^ h_n, chain_q[6] ^ g_n, chain_q[5] ^ f_n,
					chain_q[4] ^ e_n, chain_q[3] ^ d_n, chain_q[2] ^ c_n,
					chain_q[1] ^ b_n, chain_q[0] ^ a_n};
			end
			if (cmd.restart) begin
				fill_q  <= '0;
				blen_q  <= '0;
				chain_q <= sm3_pkg::IV;
			end
		end
	end

	// Byte packing, message window and working variables.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			acc_q <= {acc_q[15:0], push_byte};
			if (fill_q[1:0] == 2'd3) begin
				win_q <= {{acc_q, push_byte}, win_q[15:1]};
			end
		end
		if (cmd.round) begin
			win_q <= {w_new, win_q[15:1]};
			a_q <= a_n; b_q <= b_n; c_q <= c_n; d_q <= d_n;
			e_q <= e_n; f_q <= f_n; g_q <= g_n; h_q <= h_n;
		end else if (block_done) begin
			a_q <= chain_q[0]; b_q <= chain_q[1]; c_q <= chain_q[2]; d_q <= chain_q[3];
			e_q <= chain_q[4]; f_q <= chain_q[5]; g_q <= chain_q[6]; h_q <= chain_q[7];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sm3_ctrl.sv
// SM3 hash engine controller: input handshake, compression round count,
// padding sequence and digest output. Depends on sm3_pkg.
`default_nettype none

module sm3_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  in_has_byte,
	input  wire                  in_last,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [2:0]           out_idx,
	input  wire sm3_pkg::sm3_sts_t sts,
	output sm3_pkg::sm3_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COMP = 2'd1;
	localparam logic [1:0] ST_PAD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q, state_d;
	logic [5:0] round_q;
	logic       fin_q, mark_q, len_done_q;
	logic [2:0] len_cnt_q, out_idx_q;
	logic       in_acc, out_acc, block_full;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = (state_q == ST_OUT);
	assign out_idx    = out_idx_q;
	assign in_acc     = in_valid && in_ready;
	assign out_acc    = out_valid && out_ready;
	assign block_full = (sts.fill == sm3_pkg::FILL_LAST);

	// Commands and next state.
	always_comb begin
		cmd            = '0;
		cmd.round_idx  = round_q;
		cmd.len_idx    = len_cnt_q;
		cmd.out_idx    = out_idx_q;
		cmd.last_round = (round_q == 6'd63);
		state_d        = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd.push     = in_has_byte;
					cmd.msg_byte = in_has_byte;
					cmd.byte_sel = sm3_pkg::BSEL_IN;
					if (in_has_byte && block_full) begin
						state_d = ST_COMP;
					end else if (in_last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_COMP: begin
				cmd.round = 1'b1;
				if (round_q == 6'd63) begin
					if (!fin_q) begin
						state_d = ST_IDLE;
					end else if (len_done_q) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				if (!mark_q) begin
					cmd.byte_sel = sm3_pkg::BSEL_MARK;
				end else if (sts.fill != sm3_pkg::LEN_START && len_cnt_q == 3'd0) begin
					cmd.byte_sel = sm3_pkg::BSEL_ZERO;
				end else begin
					cmd.byte_sel = sm3_pkg::BSEL_LEN;
				end
				if (block_full) begin
					state_d = ST_COMP;
				end
			end
			ST_OUT: begin
				if (out_acc && out_idx_q == 3'd7) begin
					cmd.restart = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers. The output index wraps back to zero on the eighth word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			round_q    <= '0;
			fin_q      <= 1'b0;
			mark_q     <= 1'b0;
			len_done_q <= 1'b0;
			len_cnt_q  <= '0;
			out_idx_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.round) begin
				round_q <= round_q + 6'd1;
			end
			if (in_acc && in_last) begin
				fin_q <= 1'b1;
			end
			if (state_q == ST_PAD) begin
				if (!mark_q) begin
					mark_q <= 1'b1;
				end
				if (cmd.byte_sel == sm3_pkg::BSEL_LEN) begin
					len_cnt_q <= len_cnt_q + 3'd1;
					if (len_cnt_q == 3'd7) begin
						len_done_q <= 1'b1;
					end
				end
			end
			if (out_acc) begin
				out_idx_q <= out_idx_q + 3'd1;
			end
			if (cmd.restart) begin
				fin_q      <= 1'b0;
				mark_q     <= 1'b0;
				len_done_q <= 1'b0;
				len_cnt_q  <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sm3_hash_engine_unit.sv
// SM3 hash engine top level: joins the controller and the datapath.
// Depends on sm3_pkg, sm3_ctrl and sm3_dpath.
//
// Channel   Dir   Contents
// s_axis    in    tdata = data_byte, tuser = has_byte, tlast = last
// m_axis    out   tdata = digest_word, tuser = word_index, tlast = last_word
//
// Message byte items are taken back to back while ready. The item that fills a
// 64-byte block is followed by 64 compression rounds, one round per cycle.
// A last item starts padding: the pad and length bytes (9 to 72) are pushed
// one at a time, each full block is compressed, then eight digest items follow.
// Input ready is low during rounds, padding and digest output; a stalled
// output holds its item. Reset sets the chain to the initial value.
`default_nettype none

module sm3_hash_engine_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire  [0:0]  s_axis_tuser,   // [0] has_byte
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast
);

	sm3_pkg::sm3_cmd_t cmd;
	sm3_pkg::sm3_sts_t sts;
	logic [2:0]        out_idx;

	// Sequencing of bytes, rounds, padding and output.
	sm3_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_has_byte (s_axis_tuser[0]),
		.in_last     (s_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_idx     (out_idx),
		.sts         (sts),
		.cmd         (cmd)
	);

	// Block packing, message expansion and compression.
	sm3_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_byte     (s_axis_tdata),
		.sts         (sts),
		.digest_word (m_axis_tdata)
	);

	assign m_axis_tuser = out_idx;
	assign m_axis_tlast = (out_idx == 3'd7);

endmodule

`default_nettype wire

>>> dv/tb_sm3_hash_engine_unit.sv
// Self-checking testbench for the SM3 hash engine: streams messages byte by byte,
// predicts each 256-bit digest internally and checks every digest word.
// Depends on sm3_pkg (constants) and the sm3_hash_engine_unit RTL.

// One expected digest item.
typedef struct packed {
	logic [31:0] word;
	logic [2:0]  index;
	logic        tail;
} digest_word_t;

// Tracks the hash state of the message in flight and holds the digest words due.
class sm3_digest_checker;
	logic [31:0]  chain [8];
	logic [7:0]   block_bytes [64];
	logic [5:0]   fill;
	logic [63:0]  msg_bits;
	digest_word_t words_due [$];
	int           mismatches;
	int           words_checked;

	function new();
		mismatches = 0;
		words_checked = 0;
		restart();
	endfunction

	// Chain back to the initial vector, no bytes held, length cleared.
	function void restart();
		for (int k = 0; k < 8; k++) begin
			chain[k] = sm3_pkg::IV[k];
		end
		fill = '0;
		msg_bits = '0;
	endfunction

	function logic [31:0] rot_left(logic [31:0] x, int n);
		int k;
		k = n % 32;
		if (k == 0) begin
			return x;
		end
		return (x << k) | (x >> (32 - k));
	endfunction

	function logic [31:0] diffuse_p0(logic [31:0] x);
		return x ^ rot_left(x, 9) ^ rot_left(x, 17);
	endfunction

	function logic [31:0] diffuse_p1(logic [31:0] x);
		return x ^ rot_left(x, 15) ^ rot_left(x, 23);
	endfunction

	// Message expansion and 64 rounds, folded into the chain.
	function void compress_block();
		logic [31:0] w [68];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] tj, a12, ss1, ss2, fv, gv, tt1, tt2;
		for (int j = 0; j < 16; j++) begin
			w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2],
				block_bytes[4*j+3]};
		end
		for (int j = 16; j < 68; j++) begin
			w[j] = diffuse_p1(w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15)) ^
				rot_left(w[j-13], 7) ^ w[j-6];
		end
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int j = 0; j < 64; j++) begin
			tj = rot_left((j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH, j);
			a12 = rot_left(a, 12);
			ss1 = a12 + e + tj;
			ss1 = rot_left(ss1, 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				fv = a ^ b ^ c;
				gv = e ^ f ^ g;
			end else begin
				fv = (a & b) | (a & c) | (b & c);
				gv = (e & f) | (~e & g);
			end
			tt1 = fv + d + ss2 + (w[j] ^ w[j+4]);
			tt2 = gv + h + ss1 + w[j];
			d = c; c = rot_left(b, 9); b = a; a = tt1;
			h = g; g = rot_left(f, 19); f = e; e = diffuse_p0(tt2);
		end
		chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
		chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
	endfunction

	function void append_byte(logic [7:0] v);
		block_bytes[fill] = v;
		fill = fill + 6'd1;
		if (fill == 6'd0) begin
			compress_block();
		end
	endfunction

	// Accepted input item: take its byte, and on the closing item pad and queue the digest.
	function void absorb_item(logic [7:0] data, logic has_byte, logic fin);
		logic [63:0]  total;
		logic [7:0]   len_byte;
		digest_word_t dw;
		if (has_byte) begin
			msg_bits = msg_bits + 64'd8;
			append_byte(data);
		end
		if (!fin) begin
			return;
		end
		total = msg_bits;
		append_byte(sm3_pkg::PAD_MARK);
		while (fill != sm3_pkg::LEN_START) begin
			append_byte(8'h00);
		end
		for (int k = 0; k < 8; k++) begin
			len_byte = 8'(total >> (56 - 8 * k));
			append_byte(len_byte);
		end
		for (int k = 0; k < 8; k++) begin
			dw.word = chain[k];
			dw.index = 3'(k);
			dw.tail = (k == 7);
			words_due.push_back(dw);
		end
		restart();
	endfunction

	// Compare one digest item from the block with the oldest one due.
	function void check_word(logic [31:0] word, logic [2:0] index, logic tail);
		digest_word_t dw;
		if (words_due.size() == 0) begin
			$display("%0t: unexpected digest item word=%h index=%0d last=%b",
				$time, word, index, tail);
			mismatches++;
			return;
		end
		dw = words_due.pop_front();
		words_checked++;
		if (word !== dw.word) begin
			$display("%0t: digest word mismatch, expected %h, got %h",
				$time, dw.word, word);
			mismatches++;
		end
		if (index !== dw.index) begin
			$display("%0t: word index mismatch, expected %0d, got %0d",
				$time, dw.index, index);
			mismatches++;
		end
		if (tail !== dw.tail) begin
			$display("%0t: last word flag mismatch, expected %b, got %b",
				$time, dw.tail, tail);
			mismatches++;
		end
	endfunction

	function int pending();
		return words_due.size();
	endfunction
endclass

module tb_sm3_hash_engine_unit;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int RANDOM_ITEMS    = 330;
	localparam int IDLE_PERCENT    = 18;
	localparam int HOLD_CYCLES     = 300;
	localparam int HOLD_AT_WORDS   = 48;
	localparam int SETTLE_CYCLES   = 100;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic [0:0]  s_axis_tuser;   // [0] has_byte
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] digest_word
	logic [2:0]  m_axis_tuser;   // [2:0] word_index
	logic        m_axis_tlast;

	sm3_digest_checker digest_ref;

	int item_no;
	int msg_count;
	int byte_count;
	int noise_count;
	int cur_len;
	int longest;
	int words_seen;
	int hold_left;
	bit hold_done;

	sm3_hash_engine_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit, well above the slowest correct run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles, %0d digest words still due",
			CYCLE_LIMIT, digest_ref.pending());
		$display("DONE: errors detected");
		$finish;
	end

	// Offer one item from a falling edge and return at the falling edge after its acceptance.
	task automatic send_item(input logic [7:0] data, input logic has_byte, input logic fin);
		bit calm;
		calm = (item_no >= 150) && (item_no < 220);
		if (!calm && ($urandom_range(99) < IDLE_PERCENT)) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= has_byte;
		s_axis_tlast <= fin;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		digest_ref.absorb_item(data, has_byte, fin);
		item_no++;
		if (!has_byte && !fin) begin
			noise_count++;
		end
		if (has_byte) begin
			byte_count++;
			cur_len++;
		end
		if (fin) begin
			msg_count++;
			if (cur_len > longest) begin
				longest = cur_len;
			end
			cur_len = 0;
		end
		@(negedge clk);
	endtask

	// Stop offering and wait until every digest word due has arrived.
	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (digest_ref.pending() != 0) begin
			@(negedge clk);
		end
	endtask

	// One message of random bytes, with the occasional empty item in between.
	task automatic send_message(input int len);
		bit close_on_byte;
		close_on_byte = 1'($urandom_range(1));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 10) begin
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			end
			send_item(8'($urandom_range(255)), 1'b1, close_on_byte && (i == len - 1));
		end
		if (len == 0 || !close_on_byte) begin
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
		end
	endtask

	// Mostly short messages, some long ones, and lengths around the padding boundaries.
	function automatic int pick_length();
		int r;
		int edges [7];
		edges = '{55, 56, 57, 63, 64, 65, 120};
		r = $urandom_range(99);
		if (r < 50) begin
			return $urandom_range(0, 8);
		end else if (r < 75) begin
			return $urandom_range(9, 40);
		end
		return edges[$urandom_range(6)];
	endfunction

	// Digest monitor: check every accepted output item.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			digest_ref.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			words_seen++;
		end
	end

	// Output ready: random stalls, one long hold-off, and a stretch with no stalls.
	initial begin
		m_axis_tready = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && words_seen >= HOLD_AT_WORDS) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if (words_seen >= 80 && words_seen < 120) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Reset, directed messages, random messages, then drain and report.
	initial begin
		digest_ref = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		item_no = 0;
		msg_count = 0;
		byte_count = 0;
		noise_count = 0;
		cur_len = 0;
		longest = 0;
		words_seen = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty message; the byte on a closing item without a byte must be ignored.
		send_item(8'hFF, 1'b0, 1'b1);
		// One zero byte closed on the same item.
		send_item(8'h00, 1'b1, 1'b1);
		// The standard three-byte test vector.
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// Items without a byte mixed in, closed by an item without a byte.
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h3C, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b1);

		// Let the block drain fully before the random part.
		wait_for_drain();

		while (item_no < RANDOM_ITEMS) begin
			send_message(pick_length());
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Hashed %0d messages (%0d bytes, longest %0d, %0d empty items) and checked",
			msg_count, byte_count, longest, noise_count);
		$display("%0d digest words, with a long output hold-off and a full drain pause.",
			digest_ref.words_checked);
		if (digest_ref.mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

>>> sim.f
rtl/core/sm3_pkg.sv
rtl/core/sm3_dpath.sv
rtl/core/sm3_ctrl.sv
rtl/core/sm3_hash_engine_unit.sv
dv/tb_sm3_hash_engine_unit.sv
